FILE: rtl/gcc_pkg.sv
// Shared types and constants for the greedy coin change unit.
// Used by the interfaces, the cell row and the top level; depends on nothing.
package gcc_pkg;

	localparam int DENOM_W        = 16;
	localparam int COUNT_W        = 16;
	localparam int AMOUNT_W       = 16;
	localparam int NUM_DENOM_REGS = 7;
	localparam int CFG_INDEX_W    = 3;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_DENOMS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DENOM_0    = 3'd1;

	localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_START,
		ST_DIV,
		ST_FINISH
	} gcc_state_t;

	// sorting control broadcast to every cell
	typedef struct packed {
		logic clear;
		logic load;
	} gcc_ctrl_t;

endpackage

FILE: rtl/gcc_if.sv
// Handshake channels of the greedy coin change unit: request, response, config.
// Depends on gcc_pkg for the payload widths.
interface gcc_req_if;
	logic                          valid;
	logic                          ready;
	logic [gcc_pkg::AMOUNT_W-1:0]  amount;
	modport source (output valid, output amount, input ready);
	modport sink   (input valid, input amount, output ready);
endinterface

interface gcc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gcc_pkg::COUNT_W-1:0]   coin_count;
	logic                          impossible;
	modport source (output valid, output coin_count, output impossible, input ready);
	modport sink   (input valid, input coin_count, input impossible, output ready);
endinterface

interface gcc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [gcc_pkg::CFG_INDEX_W-1:0]  index;
	logic [gcc_pkg::DENOM_W-1:0]      data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/gcc_cell.sv
// One cell of the coin row: keeps the largest denomination it has seen and
// divides the running remainder by it bit-serially. Depends on gcc_pkg.
module gcc_cell #(
	parameter int AMOUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gcc_pkg::gcc_ctrl_t            ctrl,
	input  logic [gcc_pkg::DENOM_W-1:0]   sort_in,
	output logic [gcc_pkg::DENOM_W-1:0]   sort_out,
	input  logic                          start,
	input  logic [AMOUNT_BITS-1:0]        rem_in,
	input  logic [gcc_pkg::COUNT_W-1:0]   cnt_in,
	output logic                          done,
	output logic [AMOUNT_BITS-1:0]        rem_out,
	output logic [gcc_pkg::COUNT_W-1:0]   cnt_out
);

	localparam int BW   = $clog2(AMOUNT_BITS);
	localparam int SUMW = ((AMOUNT_BITS > gcc_pkg::COUNT_W) ? AMOUNT_BITS : gcc_pkg::COUNT_W) + 1;
	localparam int DW   = gcc_pkg::DENOM_W;

	logic [DW-1:0]                held_q;
	logic [DW-1:0]                pass_q;
	logic                         busy_q;
	logic                         done_q;
	logic [BW-1:0]                bit_q;
	logic [AMOUNT_BITS-1:0]       dvd_q;
	logic [DW-1:0]                part_q;
	logic [gcc_pkg::COUNT_W-1:0]  cnt_q;
	logic [AMOUNT_BITS-1:0]       rem_out_q;
	logic [gcc_pkg::COUNT_W-1:0]  cnt_out_q;

	logic                         skip;
	logic [DW:0]                  trial;
	logic                         qbit;
	logic [DW-1:0]                part_next;
	logic [AMOUNT_BITS-1:0]       quo_next;
	logic [AMOUNT_BITS+DW-1:0]    part_ext;
	logic [SUMW-1:0]              sum;
	logic [gcc_pkg::COUNT_W-1:0]  sum_sat;

	assign skip      = (held_q == '0);
	assign trial     = {part_q, dvd_q[AMOUNT_BITS-1]};
	assign qbit      = (trial >= {1'b0, held_q});
	assign part_next = qbit ? DW'(trial - {1'b0, held_q}) : trial[DW-1:0];
	assign quo_next  = {dvd_q[AMOUNT_BITS-2:0], qbit};
	assign part_ext  = {{AMOUNT_BITS{1'b0}}, part_next};
	assign sum       = SUMW'(cnt_q) + SUMW'(quo_next);
	assign sum_sat   = (sum > SUMW'(gcc_pkg::COUNT_SAT)) ? gcc_pkg::COUNT_SAT
	                                                      : sum[gcc_pkg::COUNT_W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (skip) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					bit_q  <= BW'(AMOUNT_BITS - 1);
				end
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: sort slot and divider datapath
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (ctrl.load) begin
			// keep the larger, hand the smaller down the row
			if (sort_in > held_q) begin
				held_q <= sort_in;
				pass_q <= held_q;
			end else begin
				pass_q <= sort_in;
			end
		end

		if (start) begin
			dvd_q  <= rem_in;
			part_q <= '0;
			cnt_q  <= cnt_in;
			if (skip) begin
				rem_out_q <= rem_in;
				cnt_out_q <= cnt_in;
			end
		end else if (busy_q) begin
			part_q <= part_next;
			dvd_q  <= quo_next;
			if (bit_q == '0) begin
				rem_out_q <= part_ext[AMOUNT_BITS-1:0];
				cnt_out_q <= sum_sat;
			end
		end
	end

	assign sort_out = pass_q;
	assign done     = done_q;
	assign rem_out  = rem_out_q;
	assign cnt_out  = cnt_out_q;

endmodule

FILE: rtl/greedy_coin_change_unit.sv
// Greedy coin change unit: config registers, sequencer and a row of gcc_cell.
// Depends on gcc_pkg, gcc_if.sv and gcc_cell.
//
// Usage
//   cfg : register writes (index 0 = num_denoms, 1..7 = denom_0..denom_6),
//         always ready; write only while the unit is idle.
//   req : one amount per beat; ready only while no item is in flight.
//   rsp : coin_count and impossible; the result sits in an output register
//         until the sink takes it.
// Each item first streams the active denominations through the cell row,
// which sorts them largest first. The remainder then walks down the row: a
// cell with a zero denomination passes it on unchanged, any other runs a
// restoring divide by its denomination. The next request is taken once the
// result has moved to the output register, so the unit takes no new amount
// while an item is in flight. If the sink stalls, the finished result waits
// in the last cell and the unit takes no new amount. Reset restores
// num_denoms = 1 and all denominations to 1 and empties the output register.
module greedy_coin_change_unit #(
	parameter int MAX_DENOMS  = 7,
	parameter int AMOUNT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	gcc_req_if.sink        req,
	gcc_rsp_if.source      rsp,
	gcc_cfg_if.sink        cfg
);

	localparam int DW  = gcc_pkg::DENOM_W;
	localparam int CW  = gcc_pkg::COUNT_W;
	localparam int LDW = ($clog2(2 * MAX_DENOMS) > 3) ? $clog2(2 * MAX_DENOMS) : 3;

	gcc_pkg::gcc_state_t  state_q, state_d;
	logic [2:0]           num_q;
	logic [DW-1:0]        denom_q [gcc_pkg::NUM_DENOM_REGS];
	logic [LDW-1:0]       ld_q, ld_d;
	logic [AMOUNT_BITS-1:0] amt_q;
	logic                 out_valid_q, out_valid_d;
	logic [CW-1:0]        out_count_q;
	logic                 out_imp_q;

	logic [2:0]           n_act;
	logic [AMOUNT_BITS+15:0] amt_ext;
	gcc_pkg::gcc_ctrl_t   ctrl;
	logic                 load_out;
	logic                 take_req;
	logic                 res_imp;

	logic [DW-1:0]          sort_link [MAX_DENOMS+1];
	logic [MAX_DENOMS:0]    start_link;
	logic [AMOUNT_BITS-1:0] rem_link  [MAX_DENOMS+1];
	logic [CW-1:0]          cnt_link  [MAX_DENOMS+1];

	assign n_act   = (num_q > 3'(MAX_DENOMS)) ? 3'(MAX_DENOMS) : num_q;
	assign amt_ext = {{AMOUNT_BITS{1'b0}}, req.amount};
	assign res_imp = (rem_link[MAX_DENOMS] != '0);

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 3'd1;
			for (int i = 0; i < gcc_pkg::NUM_DENOM_REGS; i++) begin
				denom_q[i] <= DW'(1);
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				gcc_pkg::REG_NUM_DENOMS: begin
					num_q <= cfg.data[2:0];
				end
				default: begin
					denom_q[cfg.index - gcc_pkg::REG_DENOM_0] <= cfg.data;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gcc_pkg::ST_IDLE;
			ld_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ld_q        <= ld_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ld_d          = ld_q;
		ctrl          = '0;
		take_req      = 1'b0;
		load_out      = 1'b0;
		start_link[0] = 1'b0;
		sort_link[0]  = '0;
		case (state_q)
			gcc_pkg::ST_IDLE: begin
				take_req = 1'b1;
				if (req.valid) begin
					ctrl.clear = 1'b1;
					ld_d       = '0;
					state_d    = gcc_pkg::ST_LOAD;
				end
			end
			gcc_pkg::ST_LOAD: begin
				ctrl.load = 1'b1;
				if (ld_q < LDW'(n_act)) begin
					sort_link[0] = denom_q[ld_q[2:0]];
				end
				ld_d = ld_q + 1'b1;
				if (ld_q == LDW'(2 * MAX_DENOMS - 1)) begin
					state_d = gcc_pkg::ST_START;
				end
			end
			gcc_pkg::ST_START: begin
				start_link[0] = 1'b1;
				state_d       = gcc_pkg::ST_DIV;
			end
			gcc_pkg::ST_DIV: begin
				if (start_link[MAX_DENOMS]) begin
					state_d = gcc_pkg::ST_FINISH;
				end
			end
			gcc_pkg::ST_FINISH: begin
				// hold the result in the last cell until the output register frees
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = gcc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcc_pkg::ST_IDLE;
			end
		endcase

		out_valid_d = out_valid_q;
		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (rsp.ready) begin
			out_valid_d = 1'b0;
		end
	end

	assign req.ready = take_req;

	always_ff @(posedge clk) begin
		if (take_req && req.valid) begin
			amt_q <= amt_ext[AMOUNT_BITS-1:0];
		end
		if (load_out) begin
			out_imp_q   <= res_imp;
			out_count_q <= res_imp ? '0 : cnt_link[MAX_DENOMS];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.coin_count = out_count_q;
	assign rsp.impossible = out_imp_q;

	// cell row
	assign rem_link[0] = amt_q;
	assign cnt_link[0] = '0;

	for (genvar g = 0; g < MAX_DENOMS; g++) begin : g_cell
		gcc_cell #(
			.AMOUNT_BITS (AMOUNT_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.sort_in  (sort_link[g]),
			.sort_out (sort_link[g+1]),
			.start    (start_link[g]),
			.rem_in   (rem_link[g]),
			.cnt_in   (cnt_link[g]),
			.done     (start_link[g+1]),
			.rem_out  (rem_link[g+1]),
			.cnt_out  (cnt_link[g+1])
		);
	end

	// checks
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(start_link))
		else $error("more than one cell holds the remainder");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		start_link[MAX_DENOMS] |-> state_q == gcc_pkg::ST_DIV)
		else $error("row finished outside the divide phase");

	a_imp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.impossible) |-> rsp.coin_count == '0)
		else $error("impossible result with nonzero count");

endmodule
